>>> rtl/core/crc32fd_pkg.sv
package crc32fd_pkg;

    localparam logic [7:0]  SYNC_BYTE = 8'hAA;
    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    // Result kind carried on tuser
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_CRC_OK  = 2'd1,
        KIND_CRC_BAD = 2'd2
    } t_kind;

endpackage

>>> rtl/core/crc32fd_crc_step.sv
module crc32fd_crc_step
    import crc32fd_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    // Unrolled MSB-first update over one byte
    always_comb begin
        logic [31:0] v_crc;
        v_crc = i_crc ^ {i_byte, 24'h00_0000};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[31]) begin
                v_crc = {v_crc[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[30:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

>>> rtl/core/crc32_frame_deframer.sv
// An accepted input beat reaches its result beat through the input register,
// then the result register.
// Throughput: one byte per cycle, sustained, while the result side takes beats.
// Reset: synchronous, active low; returns to sync hunting with the running
// CRC at all ones and drops any byte or result still held.
module crc32_frame_deframer
    import crc32fd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // deframed result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_length
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CRC     = 3'd4
    } t_phase;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Frame state
    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic [31:0] r_crc, n_crc;
    logic [23:0] r_rx_crc, n_rx_crc;

    // Result register
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_byte;
    logic [15:0] r_out_len;

    logic        n_emit;
    t_kind       n_kind;
    logic [7:0]  n_obyte;

    logic        w_adv;
    logic [31:0] w_crc_in;
    logic [31:0] w_crc_next;
    logic [15:0] w_len_full;
    logic [15:0] w_cnt_inc;

    // The held byte advances when the result register is empty or being drained.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_len, r_out_byte};
    assign m_axis_tuser  = r_out_kind;

    // A sync byte restarts the CRC from all ones; length and payload bytes run it on.
    assign w_crc_in   = (r_phase == PH_LEN_LO || r_phase == PH_LEN_HI ||
                         r_phase == PH_PAYLOAD) ? r_crc : CRC_INIT;
    assign w_len_full = {r_in_byte, r_len[7:0]};
    assign w_cnt_inc  = r_cnt + 16'd1;

    crc32fd_crc_step u_crc_step (
        .i_crc  (w_crc_in),
        .i_byte (r_in_byte),
        .o_crc  (w_crc_next)
    );

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_crc    = r_crc;
        n_rx_crc = r_rx_crc;
        n_emit   = 1'b0;
        n_kind   = KIND_PAYLOAD;
        n_obyte  = 8'h00;
        case (r_phase)
            PH_LEN_LO: begin
                n_crc   = w_crc_next;
                n_len   = {8'h00, r_in_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_crc    = w_crc_next;
                n_len    = w_len_full;
                n_cnt    = 16'd0;
                n_rx_crc = 24'h00_0000;
                // an empty frame goes straight to its CRC bytes
                n_phase  = (w_len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_crc   = w_crc_next;
                n_emit  = 1'b1;
                n_obyte = r_in_byte;
                if (w_cnt_inc >= r_len) begin
                    n_cnt    = 16'd0;
                    n_rx_crc = 24'h00_0000;
                    n_phase  = PH_CRC;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
            PH_CRC: begin
                if (r_cnt < 16'd3) begin
                    // collect the first three CRC bytes, MSB first
                    n_rx_crc = {r_rx_crc[15:0], r_in_byte};
                    n_cnt    = w_cnt_inc;
                end else begin
                    n_emit   = 1'b1;
                    n_kind   = ({r_rx_crc, r_in_byte} == r_crc) ? KIND_CRC_OK
                                                                 : KIND_CRC_BAD;
                    n_phase  = PH_HUNT;
                    n_cnt    = 16'd0;
                    n_rx_crc = 24'h00_0000;
                    n_crc    = CRC_INIT;
                end
            end
            default: begin
                // hunting: drop everything but the sync byte
                n_phase = PH_HUNT;
                if (r_in_byte == SYNC_BYTE) begin
                    n_crc    = w_crc_next;
                    n_cnt    = 16'd0;
                    n_rx_crc = 24'h00_0000;
                    n_phase  = PH_LEN_LO;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_HUNT;
            r_len       <= 16'd0;
            r_cnt       <= 16'd0;
            r_crc       <= CRC_INIT;
            r_rx_crc    <= 24'h00_0000;
            r_out_valid <= 1'b0;
        end else begin
            // input register: load on accept, empty once advanced
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_cnt    <= n_cnt;
                r_crc    <= n_crc;
                r_rx_crc <= n_rx_crc;
            end

            // result register: fill on a new result, drop once taken
            if (w_adv && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_adv && n_emit) begin
            r_out_kind <= n_kind;
            r_out_byte <= n_obyte;
            r_out_len  <= n_len;
        end
    end

endmodule

>>> rtl/core/crc32fd_checker.sv
module crc32fd_checker
    import crc32fd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result beat changed while stalled");

    // only the three defined kinds ever appear
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == KIND_PAYLOAD ||
                           m_axis_tuser == KIND_CRC_OK ||
                           m_axis_tuser == KIND_CRC_BAD))
        else $error("undefined result kind");

    // verdict beats carry a zero data byte
    a_verdict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD) |->
            (m_axis_tdata[7:0] == 8'h00))
        else $error("verdict beat with nonzero data byte");

    // no result right after reset, since reset empties the result register
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat right after reset");

endmodule

bind crc32_frame_deframer crc32fd_checker u_crc32fd_checker (.*);
